FILE: rtl/pfx_pkg.sv
// shared types, character codes and decode helpers for the postfix evaluator
package pfx_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int WORD_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int RADIX       = 10;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic acc_digit;
        logic push_acc;
        logic set_missing;
        logic set_divzero;
        logic pop_rd;
        logic cap_rhs;
        logic cap_lhs;
        logic alu_push;
        logic div_start;
        logic div_push;
        logic out_load;
        logic out_pop;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic err_any;
        logic is_digit;
        logic is_op;
        logic is_div;
        logic last;
        logic in_num;
        logic cnt_lt2;
        logic stack_empty;
        logic rhs_zero;
        logic div_busy;
        logic out_free;
    } t_sts;

    function automatic logic is_digit_char(input logic [CHAR_W-1:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_op_char(input logic [CHAR_W-1:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    endfunction

endpackage

FILE: rtl/pfx_ram.sv
// generic single write port ram with registered read
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pfx_dpath.sv
// datapath: character register, digit accumulator, stack, alu, divider, result register
module pfx_dpath #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfx_pkg::t_cmd             i_cmd,
    output pfx_pkg::t_sts             o_sts,
    input  logic [pfx_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [pfx_pkg::WORD_W-1:0] o_out_value,
    output logic [1:0]                o_out_status,
    output logic                      o_out_ovf
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int W  = pfx_pkg::WORD_W;
    localparam int DCW = $clog2(W + 1);

    logic [pfx_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;
    logic [W-1:0]               r_acc;
    logic                       r_in_num;
    pfx_pkg::t_status           r_err;
    logic                       r_ovf;
    logic [CW-1:0]              r_count;
    logic [W-1:0]               r_rhs;
    logic [W-1:0]               r_lhs;

    logic [W-1:0]   r_dq;
    logic [W-1:0]   r_drem;
    logic [W-1:0]   r_dvs;
    logic           r_dneg;
    logic [DCW-1:0] r_dcnt;

    logic                  r_out_valid;
    logic [W-1:0]          r_out_value;
    pfx_pkg::t_status      r_out_status;
    logic                  r_out_ovf;

    logic [W-1:0]  rd_data;
    logic [CW-1:0] cnt_m1;
    logic          full;
    logic          push_req;
    logic [W-1:0]  push_data;
    logic [W-1:0]  alu_res;
    logic [W-1:0]  quot;
    logic [W:0]    trial;
    logic [pfx_pkg::CHAR_W-1:0] dig;
    logic [W-1:0]  lhs_mag;
    logic [W-1:0]  rhs_mag;

    assign cnt_m1    = r_count - CW'(1);
    assign full      = (r_count == CW'(STACK_DEPTH));
    assign push_req  = i_cmd.push_acc | i_cmd.alu_push | i_cmd.div_push;
    assign dig       = r_char - pfx_pkg::CH_ZERO;
    assign quot      = r_dneg ? (W'(0) - r_dq) : r_dq;
    assign trial     = {r_drem, r_dq[W-1]} - {1'b0, r_dvs};
    assign lhs_mag   = r_lhs[W-1] ? (W'(0) - r_lhs) : r_lhs;
    assign rhs_mag   = r_rhs[W-1] ? (W'(0) - r_rhs) : r_rhs;

    always_comb begin
        case (r_char)
            pfx_pkg::CH_PLUS:  alu_res = r_lhs + r_rhs;
            pfx_pkg::CH_MINUS: alu_res = r_lhs - r_rhs;
            default:           alu_res = r_lhs * r_rhs;
        endcase
    end

    always_comb begin
        if (i_cmd.push_acc) begin
            push_data = r_acc;
        end else if (i_cmd.div_push) begin
            push_data = quot;
        end else begin
            push_data = alu_res;
        end
    end

    pfx_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_req && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (push_data),
        .i_raddr (cnt_m1[AW-1:0]),
        .o_rdata (rd_data)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char;
            r_last <= i_last;
        end
        if (i_cmd.cap_rhs) begin
            r_rhs <= rd_data;
        end
        if (i_cmd.cap_lhs) begin
            r_lhs <= rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_value  <= (i_cmd.out_pop && r_err == pfx_pkg::ST_OK) ? rd_data : W'(0);
            r_out_ovf    <= r_ovf;
            if (r_err != pfx_pkg::ST_OK) begin
                r_out_status <= r_err;
            end else if (i_cmd.out_pop) begin
                r_out_status <= pfx_pkg::ST_OK;
            end else begin
                r_out_status <= pfx_pkg::ST_EMPTY;
            end
        end
        // restoring divider, one quotient bit per cycle
        if (i_cmd.div_start) begin
            r_dq   <= lhs_mag;
            r_dvs  <= rhs_mag;
            r_drem <= W'(0);
            r_dneg <= r_lhs[W-1] ^ r_rhs[W-1];
        end else if (r_dcnt != DCW'(0)) begin
            if (!trial[W]) begin
                r_drem <= trial[W-1:0];
                r_dq   <= {r_dq[W-2:0], 1'b1};
            end else begin
                r_drem <= {r_drem[W-2:0], r_dq[W-1]};
                r_dq   <= {r_dq[W-2:0], 1'b0};
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= W'(0);
            r_in_num    <= 1'b0;
            r_err       <= pfx_pkg::ST_OK;
            r_ovf       <= 1'b0;
            r_count     <= CW'(0);
            r_dcnt      <= DCW'(0);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear || i_cmd.push_acc) begin
                r_acc    <= W'(0);
                r_in_num <= 1'b0;
            end else if (i_cmd.acc_digit) begin
                r_acc    <= r_acc * W'(pfx_pkg::RADIX) + W'(dig);
                r_in_num <= 1'b1;
            end

            if (i_cmd.clear) begin
                r_err <= pfx_pkg::ST_OK;
            end else if (i_cmd.set_missing) begin
                r_err <= pfx_pkg::ST_MISSING;
            end else if (i_cmd.set_divzero) begin
                r_err <= pfx_pkg::ST_DIVZERO;
            end

            if (i_cmd.clear) begin
                r_ovf <= 1'b0;
            end else if (push_req && full) begin
                r_ovf <= 1'b1;
            end

            if (i_cmd.clear) begin
                r_count <= CW'(0);
            end else if (push_req && !full) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_rd) begin
                r_count <= cnt_m1;
            end

            if (i_cmd.div_start) begin
                r_dcnt <= DCW'(W);
            end else if (r_dcnt != DCW'(0)) begin
                r_dcnt <= r_dcnt - DCW'(1);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.err_any     = (r_err != pfx_pkg::ST_OK);
    assign o_sts.is_digit    = pfx_pkg::is_digit_char(r_char);
    assign o_sts.is_op       = pfx_pkg::is_op_char(r_char);
    assign o_sts.is_div      = (r_char == pfx_pkg::CH_SLASH);
    assign o_sts.last        = r_last;
    assign o_sts.in_num      = r_in_num;
    assign o_sts.cnt_lt2     = (r_count < CW'(2));
    assign o_sts.stack_empty = (r_count == CW'(0));
    assign o_sts.rhs_zero    = (r_rhs == W'(0));
    assign o_sts.div_busy    = (r_dcnt != DCW'(0));
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;
    assign o_out_ovf    = r_out_ovf;

endmodule

FILE: rtl/pfx_ctrl.sv
// controller: sequences each character through the datapath
module pfx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pfx_pkg::t_sts i_sts,
    output pfx_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_OPCHK,
        S_POPR,
        S_POPL,
        S_ALU,
        S_DIV,
        S_TAIL,
        S_FIN,
        S_FINRD
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.err_any) begin
                    n_state = S_TAIL;
                end else if (i_sts.is_digit) begin
                    o_cmd.acc_digit = 1'b1;
                    n_state         = S_TAIL;
                end else begin
                    o_cmd.push_acc = i_sts.in_num;
                    n_state        = i_sts.is_op ? S_OPCHK : S_TAIL;
                end
            end
            S_OPCHK: begin
                if (i_sts.cnt_lt2) begin
                    o_cmd.set_missing = 1'b1;
                    n_state           = S_TAIL;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_POPR;
                end
            end
            S_POPR: begin
                o_cmd.cap_rhs = 1'b1;
                o_cmd.pop_rd  = 1'b1;
                n_state       = S_POPL;
            end
            S_POPL: begin
                o_cmd.cap_lhs = 1'b1;
                n_state       = S_ALU;
            end
            S_ALU: begin
                if (!i_sts.is_div) begin
                    o_cmd.alu_push = 1'b1;
                    n_state        = S_TAIL;
                end else if (i_sts.rhs_zero) begin
                    o_cmd.set_divzero = 1'b1;
                    n_state           = S_TAIL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_push = 1'b1;
                    n_state        = S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.push_acc = i_sts.last && i_sts.in_num && !i_sts.err_any;
                n_state        = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    if (i_sts.err_any || i_sts.stack_empty) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_FINRD;
                    end
                end
            end
            S_FINRD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_pop  = 1'b1;
                o_cmd.clear    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator
//
// Evaluates a postfix (reverse Polish) expression that arrives one ASCII character per
// request on the slave stream, with tlast on the final character. Digit runs build a
// 32-bit wrapping unsigned number, any non-digit ends the run and pushes it, and
// + - * / pop two operands and push the signed 32-bit result (wrapping, division
// truncating toward zero). After the last character one result request leaves on the
// master stream: the popped top of stack, or zero with a status of missing operands,
// division by zero or empty stack. overflow_seen reports a push dropped on a full stack.
// One character at a time is worked on. A / runs the 32-step restoring divider that
// produces one quotient bit per cycle. The stack lives in a single-port-write ram with a
// registered read, so each popped value is captured from the registered read data; after
// the last character the top of stack is read into the output register as the result.
// A finished result waits in the output register while new characters are taken; only
// the next last character waits for that register to drain.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: tdata = char_code[7:0], tlast = last_char
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    // master stream: tdata = result_value[31:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    // tuser = status[1:0], overflow_seen[2]
    output logic [2:0]  o_m_tuser
);

    pfx_pkg::t_cmd cmd;
    pfx_pkg::t_sts sts;

    // sequencing of each character
    pfx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // stack, accumulator, alu, divider and result register
    pfx_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_char       (i_s_tdata),
        .i_last       (i_s_tlast),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_value  (o_m_tdata),
        .o_out_status (o_m_tuser[1:0]),
        .o_out_ovf    (o_m_tuser[2])
    );

endmodule

FILE: rtl/pfx_chk.sv
// port-level checker for the postfix evaluator, bound to the top level
module pfx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // any non-ok status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] != pfx_pkg::ST_OK |-> o_m_tdata == 32'd0)
        else $error("error result with nonzero value");

    // one character in flight at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator pfx_chk u_pfx_chk (.*);

FILE: dv/postfix_expression_evaluator_tb.sv
// testbench for the postfix expression evaluator: directed and random expressions
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;

    localparam logic [pfx_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam int PHASE_CHARS = 110;    // least characters sent per random phase
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 64;    // covers a divide plus result forming

    // one evaluated expression as it leaves the block
    typedef struct {
        logic [pfx_pkg::WORD_W-1:0] value;
        pfx_pkg::t_status           status;
        logic                       overflow;
    } t_eval_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata;     // char_code[7:0]
    logic              i_s_tlast;     // last_char
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [31:0]       o_m_tdata;     // result_value[31:0]
    logic [2:0]        o_m_tuser;     // status[1:0], overflow_seen[2]

    // evaluator state as predicted by the testbench
    logic [pfx_pkg::WORD_W-1:0] rpn_stack [pfx_pkg::STACK_DEPTH];
    int                         rpn_depth;
    logic [pfx_pkg::WORD_W-1:0] rpn_number;
    logic                       rpn_in_number;
    pfx_pkg::t_status           rpn_error;
    logic                       rpn_overflow;

    t_eval_result      pending_results [$];
    logic [7:0]        expr_chars [$];

    int send_idle_pct;
    int recv_stall_pct;
    int chars_sent;
    int mismatches;
    bit hold_req;
    int hold_left;

    postfix_expression_evaluator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    task automatic rpn_clear();
        rpn_depth     = 0;
        rpn_number    = '0;
        rpn_in_number = 1'b0;
        rpn_error     = pfx_pkg::ST_OK;
        rpn_overflow  = 1'b0;
    endtask

    // push onto a full stack is dropped and remembered until the end
    task automatic rpn_push(input logic [pfx_pkg::WORD_W-1:0] v);
        if (rpn_depth >= pfx_pkg::STACK_DEPTH) begin
            rpn_overflow = 1'b1;
        end else begin
            rpn_stack[rpn_depth] = v;
            rpn_depth++;
        end
    endtask

    task automatic rpn_pop(output logic [pfx_pkg::WORD_W-1:0] v);
        rpn_depth--;
        v = rpn_stack[rpn_depth];
    endtask

    task automatic rpn_apply(input logic [7:0] op);
        logic [pfx_pkg::WORD_W-1:0] rhs;
        logic [pfx_pkg::WORD_W-1:0] lhs;
        logic [pfx_pkg::WORD_W-1:0] res;
        longint                     num;
        longint                     den;
        longint                     quo;
        // too few operands: error latched, stack untouched
        if (rpn_depth < 2) begin
            rpn_error = pfx_pkg::ST_MISSING;
            return;
        end
        rpn_pop(rhs);
        rpn_pop(lhs);
        case (op)
            pfx_pkg::CH_PLUS:  res = lhs + rhs;
            pfx_pkg::CH_MINUS: res = lhs - rhs;
            pfx_pkg::CH_STAR:  res = lhs * rhs;
            default: begin
                // both operands are gone already when the divisor is zero
                if (rhs == '0) begin
                    rpn_error = pfx_pkg::ST_DIVZERO;
                    return;
                end
                // 64-bit divide so most-negative / -1 wraps cleanly
                num = longint'($signed(lhs));
                den = longint'($signed(rhs));
                quo = num / den;
                res = quo[pfx_pkg::WORD_W-1:0];
            end
        endcase
        rpn_push(res);
    endtask

    // advance the predicted state by one accepted character
    task automatic evaluate_char(input logic [7:0] c, input logic last);
        t_eval_result               r;
        logic [pfx_pkg::WORD_W-1:0] digit_val;
        digit_val = {{(pfx_pkg::WORD_W - pfx_pkg::CHAR_W){1'b0}}, c - pfx_pkg::CH_ZERO};
        if (rpn_error == pfx_pkg::ST_OK) begin
            if (c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE) begin
                rpn_number    = rpn_number * pfx_pkg::RADIX + digit_val;
                rpn_in_number = 1'b1;
            end else begin
                if (rpn_in_number) begin
                    rpn_push(rpn_number);
                    rpn_number    = '0;
                    rpn_in_number = 1'b0;
                end
                if (c == pfx_pkg::CH_PLUS || c == pfx_pkg::CH_MINUS ||
                    c == pfx_pkg::CH_STAR || c == pfx_pkg::CH_SLASH)
                    rpn_apply(c);
            end
            // a number still being built is pushed by the last character
            if (last && rpn_in_number && rpn_error == pfx_pkg::ST_OK) begin
                rpn_push(rpn_number);
                rpn_in_number = 1'b0;
            end
        end
        if (last) begin
            r.value    = '0;
            r.overflow = rpn_overflow;
            if (rpn_error != pfx_pkg::ST_OK) begin
                r.status = rpn_error;
            end else if (rpn_depth == 0) begin
                r.status = pfx_pkg::ST_EMPTY;
            end else begin
                rpn_pop(r.value);
                r.status = pfx_pkg::ST_OK;
            end
            pending_results.push_back(r);
            rpn_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one character request, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        evaluate_char(c, last);
        chars_sent++;
    endtask

    // sends the collected characters, tlast on the final one
    task automatic send_expr();
        foreach (expr_chars[i])
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        expr_chars.delete();
    endtask

    task automatic put_char(input logic [7:0] c);
        expr_chars.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            expr_chars.push_back(s[i]);
    endtask

    // mostly short numbers; now and then ten to twelve digits so the value can wrap
    task automatic put_rand_number(input bit one_digit);
        int         len;
        logic [7:0] d;
        if (one_digit)
            len = 1;
        else if ($urandom_range(9) == 0)
            len = $urandom_range(10, 12);
        else
            len = $urandom_range(1, 3);
        repeat (len) begin
            d = 8'($urandom_range(9));
            put_char(pfx_pkg::CH_ZERO + d);
        end
    endtask

    function automatic logic [7:0] rand_op();
        case ($urandom_range(3))
            0:       return pfx_pkg::CH_PLUS;
            1:       return pfx_pkg::CH_MINUS;
            2:       return pfx_pkg::CH_STAR;
            default: return pfx_pkg::CH_SLASH;
        endcase
    endfunction

    // a space most of the time, otherwise any code that is neither digit nor operator
    function automatic logic [7:0] rand_separator();
        logic [7:0] c;
        if ($urandom_range(3) != 0)
            return CH_SPACE;
        do begin
            c = 8'($urandom_range(255));
        end while ((c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE) ||
                   c == pfx_pkg::CH_PLUS || c == pfx_pkg::CH_MINUS ||
                   c == pfx_pkg::CH_STAR || c == pfx_pkg::CH_SLASH);
        return c;
    endfunction

    // mostly well-formed postfix with random operands and operators
    task automatic put_rand_expr(input int operands);
        int depth;
        depth = 0;
        for (int i = 0; i < operands; i++) begin
            put_rand_number(1'b0);
            // an occasional missing separator merges two numbers
            if ($urandom_range(9) != 0)
                put_char(rand_separator());
            depth++;
            while (depth >= 2 && $urandom_range(1) == 0) begin
                put_char(rand_op());
                depth--;
            end
        end
        while (depth >= 2) begin
            put_char(rand_op());
            depth--;
        end
        // a stray operator at the end runs short of operands
        if ($urandom_range(9) == 0)
            put_char(rand_op());
        if ($urandom_range(9) == 0)
            put_char(rand_separator());
    endtask

    // single-digit pushes, as many as the caller asks, then the given number of operators
    task automatic put_deep_expr(input int operands, input int ops);
        for (int i = 0; i < operands; i++) begin
            put_rand_number(1'b1);
            put_char(CH_SPACE);
        end
        repeat (ops) put_char(rand_op());
    endtask

    // random characters of any kind
    task automatic put_noise(input int len);
        logic [7:0] d;
        repeat (len) begin
            case ($urandom_range(2))
                0: put_char(8'($urandom_range(255)));
                1: put_char(rand_op());
                default: begin
                    d = 8'($urandom_range(9));
                    put_char(pfx_pkg::CH_ZERO + d);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // random stalls, or a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // every result request is matched against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_eval_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual value %0d status %0d overflow %0b",
                         $time, $signed(o_m_tdata), o_m_tuser[1:0], o_m_tuser[2]);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.value || o_m_tuser[1:0] !== want.status ||
                    o_m_tuser[2] !== want.overflow) begin
                    mismatches++;
                    $display("%0t: expected value %0d status %0d overflow %0b, actual value %0d status %0d overflow %0b",
                             $time, $signed(want.value), want.status, want.overflow,
                             $signed(o_m_tdata), o_m_tuser[1:0], o_m_tuser[2]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // all four operators, truncating division, a digit as the last character
    task automatic test_operators();
        put_text("9");
        send_expr();
        put_text("3 4+5*");
        send_expr();
        put_text("20 0 7-/");
        send_expr();
    endtask

    // missing operands with digits ignored after, zero divisor, empty stack
    task automatic test_error_cases();
        put_text("+9");
        send_expr();
        put_text("7 0/");
        send_expr();
        put_char(8'hFF);
        send_expr();
    endtask

    // 2147483648 reads back as the most negative value, then divided by -1
    task automatic test_number_edges();
        put_text("2147483648");
        put_char(8'h00);
        put_text("0 1-/");
        send_expr();
    endtask

    // pushes past the stack depth are dropped and flagged
    task automatic test_full_stack();
        put_deep_expr(pfx_pkg::STACK_DEPTH + 2, 1);
        send_expr();
    endtask

    // receiver holds off long enough for a finished result to block the next one
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (6) begin
            put_rand_expr(2);
            send_expr();
        end
    endtask

    task automatic test_random_phases();
        int start;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS) begin
                case ($urandom_range(99)) inside
                    [0:3]:   put_deep_expr($urandom_range(pfx_pkg::STACK_DEPTH - 3,
                                                          pfx_pkg::STACK_DEPTH + 5),
                                           $urandom_range(1, 5));
                    [4:19]:  put_noise($urandom_range(1, 10));
                    default: put_rand_expr($urandom_range(1, 8));
                endcase
                send_expr();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        <= 1'b0;
        i_s_tvalid     <= 1'b0;
        i_s_tdata      <= '0;
        i_s_tlast      <= 1'b0;
        i_m_tready     <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        chars_sent     = 0;
        mismatches     = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        rpn_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operators();
        test_error_cases();
        test_number_edges();
        test_full_stack();
        test_backpressure();
        test_random_phases();

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
